/* hw/rtl/bbst_pkg.sv */
`default_nettype none
// ============================================================================
// bbst_pkg
// Shared constants, types and the control program of the bracket balance
// segment tree unit.
// ============================================================================
package bbst_pkg;

    // Sizes of the sequence and of the tree.
    localparam int MAX_LEN    = 32768;
    localparam int POS_W      = $clog2(MAX_LEN);
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 16;
    localparam int NODE_DEPTH = 2 * MAX_LEN;
    localparam int NODE_AW    = $clog2(NODE_DEPTH);

    // Command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_FLIP  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Datapath operations driven by one control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_FETCH,
        OP_START,
        OP_DESCEND,
        OP_LEAF,
        OP_READ_SIB,
        OP_MERGE,
        OP_EMIT
    } op_t;

    // Jump conditions; a true condition loads the target, else the step advances.
    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_CLEAR_BUSY,
        COND_NOT_ACCEPTED,
        COND_IS_CHECK,
        COND_IS_IGNORE,
        COND_LO_LT_HI,
        COND_NODE_ROOT,
        COND_PARENT_NOT_ROOT,
        COND_OUT_BUSY
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Step addresses of the program.
    localparam step_t STEP_CLEAR   = 4'd0;
    localparam step_t STEP_FETCH   = 4'd1;
    localparam step_t STEP_DECODE  = 4'd2;
    localparam step_t STEP_FILTER  = 4'd3;
    localparam step_t STEP_START   = 4'd4;
    localparam step_t STEP_DESCEND = 4'd5;
    localparam step_t STEP_LEAF    = 4'd6;
    localparam step_t STEP_SIB     = 4'd7;
    localparam step_t STEP_MERGE   = 4'd8;
    localparam step_t STEP_RETURN  = 4'd9;
    localparam step_t STEP_EMIT    = 4'd10;
    localparam step_t STEP_DONE    = 4'd11;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Status flags from the datapath that the jump conditions test.
    typedef struct packed {
        logic in_valid;
        logic clear_last;
        logic is_check;
        logic is_ignore;
        logic lo_lt_hi;
        logic node_root;
        logic parent_root;
        logic out_busy;
    } status_t;

    // The control program.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t word;
        unique case (step)
            STEP_CLEAR:   word = '{OP_CLEAR,    COND_CLEAR_BUSY,      STEP_CLEAR};
            STEP_FETCH:   word = '{OP_FETCH,    COND_NOT_ACCEPTED,    STEP_FETCH};
            STEP_DECODE:  word = '{OP_NOP,      COND_IS_CHECK,        STEP_EMIT};
            STEP_FILTER:  word = '{OP_NOP,      COND_IS_IGNORE,       STEP_FETCH};
            STEP_START:   word = '{OP_START,    COND_NONE,            STEP_FETCH};
            STEP_DESCEND: word = '{OP_DESCEND,  COND_LO_LT_HI,        STEP_DESCEND};
            STEP_LEAF:    word = '{OP_LEAF,     COND_NODE_ROOT,       STEP_FETCH};
            STEP_SIB:     word = '{OP_READ_SIB, COND_NONE,            STEP_FETCH};
            STEP_MERGE:   word = '{OP_MERGE,    COND_PARENT_NOT_ROOT, STEP_SIB};
            STEP_RETURN:  word = '{OP_NOP,      COND_ALWAYS,          STEP_FETCH};
            STEP_EMIT:    word = '{OP_EMIT,     COND_OUT_BUSY,        STEP_EMIT};
            STEP_DONE:    word = '{OP_NOP,      COND_ALWAYS,          STEP_FETCH};
            default:      word = '{OP_NOP,      COND_ALWAYS,          STEP_FETCH};
        endcase
        return word;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/bbst_if.sv */
`default_nettype none
// ============================================================================
// bbst_if
// Valid/ready channels for command items and check result items.
// ============================================================================
interface bbst_item_if
    import bbst_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [POS_W-1:0] position;
    logic             bracket;

    modport source (output valid, output cmd, output position, output bracket, input ready);
    modport sink   (input valid, input cmd, input position, input bracket, output ready);
endinterface

interface bbst_result_if
    import bbst_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             balanced;
    logic [CNT_W-1:0] open_unmatched;
    logic [CNT_W-1:0] close_unmatched;

    modport source (output valid, output balanced, output open_unmatched,
                    output close_unmatched, input ready);
    modport sink   (input valid, input balanced, input open_unmatched,
                    input close_unmatched, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bbst_ram.sv */
`default_nettype none
// ============================================================================
// bbst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module bbst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bbst_sequencer.sv */
`default_nettype none
// ============================================================================
// bbst_sequencer
// Step counter over the control program, with conditional jumps on datapath
// status.
// ============================================================================
module bbst_sequencer
    import bbst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output op_t          op
);

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t word;
    logic   take;

    assign word = ucode_rom(pc_reg);
    assign op   = word.op;

    // Evaluate the jump condition of the current control word.
    always_comb
    begin
        unique case (word.cond)
            COND_NONE:            take = 1'b0;
            COND_ALWAYS:          take = 1'b1;
            COND_CLEAR_BUSY:      take = !status.clear_last;
            COND_NOT_ACCEPTED:    take = !status.in_valid;
            COND_IS_CHECK:        take = status.is_check;
            COND_IS_IGNORE:       take = status.is_ignore;
            COND_LO_LT_HI:        take = status.lo_lt_hi;
            COND_NODE_ROOT:       take = status.node_root;
            COND_PARENT_NOT_ROOT: take = !status.parent_root;
            COND_OUT_BUSY:        take = status.out_busy;
            default:              take = 1'b1;
        endcase
        pc_next = take ? word.target : STEP_W'(pc_reg + 1'b1);
    end

    // Step counter; after reset the program starts with the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bbst_datapath.sv */
`default_nettype none
// ============================================================================
// bbst_datapath
// Command registers, descent range, tree node memory, bracket memory, merge
// unit, cached root counts and the result register.
// ============================================================================
module bbst_datapath
    import bbst_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_wdata,
    input  wire op_t              op,
    output status_t               status,
    bbst_item_if.sink             items,
    bbst_result_if.source         results
);

    // Configuration and effective length.
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] eff_len;
    logic [POS_W-1:0] hi_init;

    // Command item.
    logic [1:0]       cmd_reg;
    logic [POS_W-1:0] pos_reg;
    logic             br_reg;

    // Walk state.
    logic [POS_W-1:0]   lo_reg;
    logic [POS_W-1:0]   hi_reg;
    logic [NODE_AW-1:0] node_reg;
    logic [CNT_W-1:0]   cur_open_reg;
    logic [CNT_W-1:0]   cur_close_reg;
    logic [NODE_AW-1:0] clr_reg;
    logic [CNT_W-1:0]   root_open_reg;
    logic [CNT_W-1:0]   root_close_reg;

    // Result register.
    logic             out_valid_reg;
    logic             out_bal_reg;
    logic [CNT_W-1:0] out_open_reg;
    logic [CNT_W-1:0] out_close_reg;

    // Combinational helpers.
    logic [POS_W:0]       mid_sum;
    logic [POS_W-1:0]     mid;
    logic [NODE_AW-1:0]   node_p1;
    logic [NODE_AW-1:0]   node_m1;
    logic [NODE_AW-1:0]   parent;
    logic [NODE_AW-1:0]   sibling;
    logic                 new_bit;
    logic [CNT_W-1:0]     l_open, l_close, r_open, r_close, m;
    logic [CNT_W-1:0]     mrg_open, mrg_close;
    logic                 accept;

    // Memory ports.
    logic                 node_we;
    logic [NODE_AW-1:0]   node_waddr;
    logic [2*CNT_W-1:0]   node_wdata;
    logic [2*CNT_W-1:0]   node_rdata;
    logic                 br_rdata;

    // Length 0 acts as 1 and lengths above the maximum are clipped.
    always_comb
    begin
        priority if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_LEN))
        begin
            eff_len = LEN_W'(MAX_LEN);
        end
        else
        begin
            eff_len = len_reg;
        end
    end
    assign hi_init = POS_W'(eff_len - 1'b1);

    // Range split and heap index arithmetic.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[POS_W:1];
    assign node_p1 = node_reg + 1'b1;
    assign node_m1 = node_reg - 1'b1;
    assign parent  = {1'b0, node_m1[NODE_AW-1:1]};
    assign sibling = node_reg[0] ? node_p1 : node_m1;

    // New bracket value: load takes the item's bracket, flip inverts the store.
    assign new_bit = (cmd_reg == CMD_LOAD) ? br_reg : !br_rdata;

    // Merge: an odd node is a left child; the left opens match the right closes.
    always_comb
    begin
        if (node_reg[0])
        begin
            l_open  = cur_open_reg;
            l_close = cur_close_reg;
            r_open  = node_rdata[2*CNT_W-1:CNT_W];
            r_close = node_rdata[CNT_W-1:0];
        end
        else
        begin
            l_open  = node_rdata[2*CNT_W-1:CNT_W];
            l_close = node_rdata[CNT_W-1:0];
            r_open  = cur_open_reg;
            r_close = cur_close_reg;
        end
        m         = (l_open < r_close) ? l_open : r_close;
        mrg_open  = l_open + r_open - m;
        mrg_close = l_close + r_close - m;
    end

    // Node memory write selection.
    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = node_reg;
        node_wdata = '0;
        unique case (op)
            OP_CLEAR:
            begin
                node_we    = 1'b1;
                node_waddr = clr_reg;
                node_wdata = '0;
            end
            OP_LEAF:
            begin
                node_we    = 1'b1;
                node_waddr = node_reg;
                node_wdata = new_bit ? {CNT_W'(0), CNT_W'(1)} : {CNT_W'(1), CNT_W'(0)};
            end
            OP_MERGE:
            begin
                node_we    = 1'b1;
                node_waddr = parent;
                node_wdata = {mrg_open, mrg_close};
            end
            default:
            begin
                node_we    = 1'b0;
            end
        endcase
    end

    bbst_ram #(
        .WIDTH (2 * CNT_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (op == OP_READ_SIB),
        .raddr (sibling),
        .rdata (node_rdata)
    );

    bbst_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LEN)
    ) u_bracket_ram (
        .clk   (clk),
        .we    (op == OP_LEAF),
        .waddr (pos_reg),
        .wdata (new_bit),
        .re    (op == OP_START),
        .raddr (pos_reg),
        .rdata (br_rdata)
    );

    // Handshake and status.
    assign items.ready = (op == OP_FETCH);
    assign accept      = items.valid && items.ready;

    assign status.in_valid    = items.valid;
    assign status.clear_last  = (clr_reg == {NODE_AW{1'b1}});
    assign status.is_check    = (cmd_reg == CMD_CHECK);
    assign status.is_ignore   = (cmd_reg != CMD_LOAD && cmd_reg != CMD_FLIP)
                              || ({1'b0, pos_reg} >= eff_len);
    assign status.lo_lt_hi    = (lo_reg < hi_reg);
    assign status.node_root   = (node_reg == '0);
    assign status.parent_root = (parent == '0);
    assign status.out_busy    = out_valid_reg && !results.ready;

    // Configuration, clearing counter and cached root counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= LEN_W'(1);
            clr_reg        <= '0;
            root_open_reg  <= '0;
            root_close_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            if (op == OP_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (node_we && node_waddr == '0)
            begin
                root_open_reg  <= node_wdata[2*CNT_W-1:CNT_W];
                root_close_reg <= node_wdata[CNT_W-1:0];
            end
        end
    end

    // Item capture and the walk registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= items.cmd;
            pos_reg <= items.position;
            br_reg  <= items.bracket;
        end
        unique case (op)
            OP_START:
            begin
                lo_reg   <= '0;
                hi_reg   <= hi_init;
                node_reg <= '0;
            end
            OP_DESCEND:
            begin
                if (lo_reg < hi_reg)
                begin
                    if (pos_reg <= mid)
                    begin
                        node_reg <= {node_reg[NODE_AW-2:0], 1'b1};
                        hi_reg   <= mid;
                    end
                    else
                    begin
                        node_reg <= {node_p1[NODE_AW-2:0], 1'b0};
                        lo_reg   <= POS_W'(mid + 1'b1);
                    end
                end
            end
            OP_LEAF:
            begin
                cur_open_reg  <= new_bit ? CNT_W'(0) : CNT_W'(1);
                cur_close_reg <= new_bit ? CNT_W'(1) : CNT_W'(0);
            end
            OP_MERGE:
            begin
                node_reg      <= parent;
                cur_open_reg  <= mrg_open;
                cur_close_reg <= mrg_close;
            end
            default:
            begin
            end
        endcase
    end

    // Result register: filled by a check, freed when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op == OP_EMIT && !status.out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_EMIT && !status.out_busy)
        begin
            out_bal_reg   <= (root_open_reg == '0) && (root_close_reg == '0);
            out_open_reg  <= root_open_reg;
            out_close_reg <= root_close_reg;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.balanced        = out_bal_reg;
    assign results.open_unmatched  = out_open_reg;
    assign results.close_unmatched = out_close_reg;

endmodule
`default_nettype wire

/* hw/rtl/bracket_balance_segment_tree_unit.sv */
`default_nettype none
// ============================================================================
// bracket_balance_segment_tree_unit
// Bracket sequence with a segment tree of unmatched open/close counts.
// ============================================================================
// Usage:
//   items   : command items (cmd, position, bracket). Load writes a bracket,
//             flip toggles one, check reports the root. Out-of-range loads,
//             flips and the unused command are dropped.
//   results : one item per check (balanced, open_unmatched, close_unmatched),
//             held in an output register until the receiver takes it.
//   cfg_we/cfg_wdata : seq_length, written while the unit is idle.
// Sequence (from acceptance to the next acceptance):
//   load/flip : the walk descends level by level from the root to the leaf of
//               the position and writes the leaf; at a length of one the leaf
//               is the root itself. Each level up then takes a sibling read
//               plus a parent write, both on the node memory.
//   check     : the root counts are cached in registers; the result register
//               is loaded once the output register is free.
//   dropped   : decoded and filtered out, then the next item is fetched.
// Reset: a clearing pass writes zero to all 2*MAX_LEN (65536) tree nodes, one
//   per cycle; no item is accepted during the pass.
// Stall: a check waits while the output register is still full; the unit takes
//   no new item until that check has been placed.
// ============================================================================
module bracket_balance_segment_tree_unit
    import bbst_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_wdata,
    bbst_item_if.sink             items,
    bbst_result_if.source         results
);

    op_t     op;
    status_t status;

    bbst_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    bbst_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .status    (status),
        .items     (items),
        .results   (results)
    );

    // No item is taken while the node memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_CLEAR) |-> !items.ready)
    else $error("item accepted during clearing pass");

    // A result appears only after the check step placed it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(op == OP_EMIT))
    else $error("result raised without a check");

    // The upward walk continues with a sibling read until the root is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_MERGE && !status.parent_root) |=> (op == OP_READ_SIB))
    else $error("upward walk stopped below the root");

endmodule
`default_nettype wire
